FILE: design/gwpf_pkg.sv
`default_nettype none
package gwpf_pkg;

  localparam int GRID_DIM_DEF   = 32;
  localparam int PATH_DEPTH_DEF = 1024;

  localparam int COORD_W  = 5;
  localparam int CHAR_W   = 8;
  localparam int LIMIT_W  = 10;
  localparam int STATUS_W = 3;
  localparam int LBL_W    = 11;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET   = LIMIT_W'(34 * 10);
  localparam logic [LBL_W-1:0]   LABEL_FREE    = 11'h7FE;
  localparam logic [LBL_W-1:0]   LABEL_BLOCKED = 11'h7FF;
  localparam logic [CHAR_W-1:0]  CHAR_BLK_LO   = 8'h30;
  localparam logic [CHAR_W-1:0]  CHAR_BLK_HI   = 8'h35;

  typedef enum logic [1:0] {
    MODE_LOAD,
    MODE_SEARCH,
    MODE_POP,
    MODE_CLEAR
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE,
    ST_FOUND,
    ST_UNREACH,
    ST_PENDING,
    ST_WAY,
    ST_NOWAY
  } status_e;

  typedef struct packed {
    logic    clr_en;
    logic    load_wr;
    logic    latch;
    logic    init_en;
    logic    wave_clr;
    logic    wave_en;
    logic    goal_rd;
    logic    trace_start;
    logic    trace_en;
    logic    pop_rd;
    logic    clear;
    logic    out_load;
    status_e out_status;
    logic    out_way;
  } cmd_t;

  typedef struct packed {
    logic range_ok;
    logic sweep_last;
    logic init_done;
    logic wave_done;
    logic changed;
    logic goal_free;
    logic goal_lbl_ok;
    logic step_over;
    logic stack_empty;
    logic trace_done;
  } sts_t;

endpackage
`default_nettype wire

FILE: design/gwpf_ctrl.sv
`default_nettype none
module gwpf_ctrl import gwpf_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  input  mode_e mode_i,
  output logic  out_valid_o,
  input  logic  out_stall_i,
  input  sts_t  sts_i,
  output cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_INIT,
    S_WAVE,
    S_WEND,
    S_WCHK,
    S_TRACE,
    S_FIN
  } state_e;

  state_e  state_q, state_d;
  status_e res_q, res_d;
  logic    way_q, way_d;
  logic    out_valid_q, out_valid_d;
  logic    out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    res_d       = res_q;
    way_d       = way_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      S_CLR: begin
        cmd_o.clr_en = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          way_d   = 1'b0;
          res_d   = ST_DONE;
          state_d = S_FIN;
          unique case (mode_i)
            MODE_LOAD: begin
              cmd_o.load_wr = 1'b1;
            end
            MODE_SEARCH: begin
              if (sts_i.range_ok) begin
                cmd_o.latch = 1'b1;
                state_d     = S_INIT;
              end else begin
                res_d = ST_UNREACH;
              end
            end
            MODE_POP: begin
              if (sts_i.stack_empty) begin
                res_d = ST_NOWAY;
              end else begin
                cmd_o.pop_rd = 1'b1;
                res_d        = ST_WAY;
                way_d        = 1'b1;
              end
            end
            MODE_CLEAR: begin
              cmd_o.clear = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_INIT: begin
        cmd_o.init_en = 1'b1;
        if (sts_i.init_done) begin
          cmd_o.wave_clr = 1'b1;
          state_d        = S_WAVE;
        end
      end
      S_WAVE: begin
        cmd_o.wave_en = 1'b1;
        if (sts_i.wave_done) begin
          state_d = S_WEND;
        end
      end
      S_WEND: begin
        cmd_o.goal_rd = 1'b1;
        state_d       = S_WCHK;
      end
      S_WCHK: begin
        priority if (sts_i.goal_free && !sts_i.step_over && sts_i.changed) begin
          cmd_o.wave_clr = 1'b1;
          state_d        = S_WAVE;
        end else if (!sts_i.goal_lbl_ok) begin
          res_d   = ST_UNREACH;
          state_d = S_FIN;
        end else if (!sts_i.stack_empty) begin
          res_d   = ST_PENDING;
          state_d = S_FIN;
        end else begin
          cmd_o.trace_start = 1'b1;
          state_d           = S_TRACE;
        end
      end
      S_TRACE: begin
        cmd_o.trace_en = 1'b1;
        if (sts_i.trace_done) begin
          res_d   = ST_FOUND;
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    cmd_o.out_status = res_q;
    cmd_o.out_way    = way_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      res_q       <= ST_DONE;
      way_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_q       <= res_d;
      way_q       <= way_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
`default_nettype wire

FILE: design/gwpf_dp.sv
`default_nettype none
module gwpf_dp import gwpf_pkg::*; #(
  parameter int GRID_DIM   = GRID_DIM_DEF,
  parameter int PATH_DEPTH = PATH_DEPTH_DEF,
  localparam int NW = $clog2(PATH_DEPTH + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  input  logic                cfg_valid_i,
  input  logic [LIMIT_W-1:0]  cfg_data_i,
  input  logic [COORD_W-1:0]  cell_row_i,
  input  logic [COORD_W-1:0]  cell_col_i,
  input  logic [CHAR_W-1:0]   cell_char_i,
  input  logic [COORD_W-1:0]  start_row_i,
  input  logic [COORD_W-1:0]  start_col_i,
  input  logic [COORD_W-1:0]  goal_row_i,
  input  logic [COORD_W-1:0]  goal_col_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [COORD_W-1:0]  way_row_o,
  output logic [COORD_W-1:0]  way_col_o,
  output logic [NW-1:0]       path_length_o
);

  localparam int CW    = $clog2(GRID_DIM);
  localparam int CELLS = GRID_DIM * GRID_DIM;
  localparam int AW    = $clog2(CELLS);
  localparam int IW    = AW + 1;
  localparam int SW    = $clog2(PATH_DEPTH);
  localparam int EW    = 2 * CW;
  localparam logic [CW-1:0] DM1      = CW'(GRID_DIM - 1);
  localparam logic [CW-1:0] DM2      = CW'(GRID_DIM - 2);
  localparam logic [CW-1:0] DM3      = CW'(GRID_DIM - 3);
  localparam logic [CW-1:0] C_ONE    = CW'(1);
  localparam logic [CW-1:0] C_TWO    = CW'(2);
  localparam logic [IW-1:0] IDX_END  = IW'(CELLS);
  localparam logic [IW-1:0] IDX_LAST = IW'(CELLS - 1);
  localparam logic [NW-1:0] DEPTH_N  = NW'(PATH_DEPTH);

  function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] r, input logic [CW-1:0] c);
    return AW'(32'(r) * GRID_DIM + 32'(c));
  endfunction

  logic             obst_mem [CELLS];
  logic [LBL_W-1:0] dist_mem [CELLS];
  logic [EW-1:0]    stack_mem [PATH_DEPTH];

  logic [CW-1:0]      sr_q, sc_q, gr_q, gc_q;
  logic [LIMIT_W-1:0] limit_q;
  logic [IW-1:0]      idx_q, idx_m1;
  logic               obst_rd_q;
  logic [LBL_W-1:0]   dist_rd_q;
  logic [EW-1:0]      stack_rd_q;
  logic [NW-1:0]      cnt_q, cnt_m1;
  logic [LBL_W-1:0]   step_q;
  logic [CW-1:0]      wr_q, wc_q;
  logic [2:0]         ph_q;
  logic               hit_q, changed_q;
  logic [CW-1:0]      tr_q, tc_q;
  logic [LBL_W-1:0]   k_q, want;
  logic [1:0]         td_q;
  logic               tv_q;
  status_e            status_q;
  logic [COORD_W-1:0] way_row_q, way_col_q;
  logic [NW-1:0]      plen_q;

  logic [CW-1:0] in_cr, in_cc;
  logic          cell_ok, blk;
  logic [AW-1:0] start_a, goal_a;

  logic [7:0]    nv;
  logic          row_in, col_in;
  logic [CW-1:0] pr, pc;
  logic          rd_w, hit_nx, cell_end;

  logic          inb, match, tdone, tstep;
  logic [CW-1:0] tnr, tnc;

  logic             push_en;
  logic [EW-1:0]    push_data;
  logic             d_we, d_re;
  logic [AW-1:0]    d_wa, d_ra;
  logic [LBL_W-1:0] d_wd;

  assign in_cr   = CW'(cell_row_i);
  assign in_cc   = CW'(cell_col_i);
  assign cell_ok = (32'(cell_row_i) < GRID_DIM) && (32'(cell_col_i) < GRID_DIM);
  assign blk     = (cell_char_i >= CHAR_BLK_LO) && (cell_char_i <= CHAR_BLK_HI);
  assign start_a = cell_addr(sr_q, sc_q);
  assign goal_a  = cell_addr(gr_q, gc_q);
  assign idx_m1  = idx_q - 1'b1;
  assign cnt_m1  = cnt_q - 1'b1;

  // wave: neighbor spreads only if it is an interior cell
  always_comb begin
    row_in = (wr_q >= C_ONE) && (wr_q <= DM2);
    col_in = (wc_q >= C_ONE) && (wc_q <= DM2);
    nv     = '0;
    nv[0]  = 1'b1;
    nv[1]  = (wc_q >= C_TWO) && row_in;
    nv[2]  = (wc_q <= DM3) && row_in;
    nv[3]  = (wr_q >= C_TWO) && col_in;
    nv[4]  = (wr_q <= DM3) && col_in;
    pr = wr_q;
    pc = wc_q;
    unique case (ph_q)
      3'd1:    pc = wc_q - 1'b1;
      3'd2:    pc = wc_q + 1'b1;
      3'd3:    pr = wr_q - 1'b1;
      3'd4:    pr = wr_q + 1'b1;
      default: ;
    endcase
    rd_w = (ph_q == 3'd0) ||
           ((ph_q <= 3'd4) && nv[ph_q] && ((ph_q != 3'd1) || (dist_rd_q == LABEL_FREE)));
    hit_nx = (ph_q >= 3'd2) ?
             (hit_q || (nv[ph_q - 3'd1] && (dist_rd_q == step_q))) : 1'b0;
    cell_end = ((ph_q == 3'd1) && (dist_rd_q != LABEL_FREE)) || (ph_q == 3'd5);
  end

  // trace: left, right, up, down
  always_comb begin
    tnr = tr_q;
    tnc = tc_q;
    unique case (td_q)
      2'd0: begin inb = (tc_q != '0);  tnc = tc_q - 1'b1; end
      2'd1: begin inb = (tc_q != DM1); tnc = tc_q + 1'b1; end
      2'd2: begin inb = (tr_q != '0);  tnr = tr_q - 1'b1; end
      default: begin inb = (tr_q != DM1); tnr = tr_q + 1'b1; end
    endcase
    want  = k_q - 1'b1;
    match = tv_q && (dist_rd_q == want);
    tdone = (k_q == '0) ||
            ((td_q == 2'd3) && ((!tv_q && !inb) || (tv_q && !match)));
    tstep = cmd_i.trace_en && (k_q != '0);
  end

  assign push_en   = cmd_i.trace_start || (tstep && match);
  assign push_data = cmd_i.trace_start ? {gr_q, gc_q} : {tnr, tnc};

  always_comb begin
    d_we = 1'b0;
    d_wa = start_a;
    d_wd = LABEL_FREE;
    if (cmd_i.init_en && (idx_q != '0)) begin
      d_we = 1'b1;
      d_wa = idx_m1[AW-1:0];
      if (idx_m1[AW-1:0] == start_a) begin
        d_wd = '0;
      end else begin
        d_wd = obst_rd_q ? LABEL_BLOCKED : LABEL_FREE;
      end
    end else if (cmd_i.wave_en && (ph_q == 3'd5) && hit_nx) begin
      d_we = 1'b1;
      d_wa = cell_addr(wr_q, wc_q);
      d_wd = step_q + 1'b1;
    end
    d_re = 1'b0;
    d_ra = goal_a;
    if (cmd_i.wave_en && rd_w) begin
      d_re = 1'b1;
      d_ra = cell_addr(pr, pc);
    end else if (cmd_i.goal_rd) begin
      d_re = 1'b1;
    end else if (tstep && !tv_q && inb) begin
      d_re = 1'b1;
      d_ra = cell_addr(tnr, tnc);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_en) begin
      obst_mem[idx_q[AW-1:0]] <= 1'b0;
    end else if (cmd_i.load_wr && cell_ok) begin
      obst_mem[cell_addr(in_cr, in_cc)] <= blk;
    end
    if (cmd_i.init_en && (idx_q < IDX_END)) begin
      obst_rd_q <= obst_mem[idx_q[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (d_we) begin
      dist_mem[d_wa] <= d_wd;
    end
    if (d_re) begin
      dist_rd_q <= dist_mem[d_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_en && (cnt_q < DEPTH_N)) begin
      stack_mem[cnt_q[SW-1:0]] <= push_data;
    end
    if (cmd_i.pop_rd) begin
      stack_rd_q <= stack_mem[cnt_m1[SW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      sr_q <= CW'(start_row_i);
      sc_q <= CW'(start_col_i);
      gr_q <= CW'(goal_row_i);
      gc_q <= CW'(goal_col_i);
    end
    if (cmd_i.trace_start) begin
      tr_q <= gr_q;
      tc_q <= gc_q;
      k_q  <= dist_rd_q;
    end else if (tstep && match) begin
      tr_q <= tnr;
      tc_q <= tnc;
      k_q  <= want;
    end
    if (cmd_i.out_load) begin
      status_q  <= cmd_i.out_status;
      way_row_q <= cmd_i.out_way ? COORD_W'(stack_rd_q[EW-1:CW]) : '0;
      way_col_q <= cmd_i.out_way ? COORD_W'(stack_rd_q[CW-1:0]) : '0;
      plen_q    <= cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q   <= LIMIT_RESET;
      idx_q     <= '0;
      cnt_q     <= '0;
      step_q    <= '0;
      wr_q      <= '0;
      wc_q      <= '0;
      ph_q      <= '0;
      hit_q     <= 1'b0;
      changed_q <= 1'b0;
      td_q      <= '0;
      tv_q      <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        limit_q <= cfg_data_i;
      end
      if (cmd_i.latch) begin
        idx_q <= '0;
      end else if (cmd_i.clr_en) begin
        idx_q <= (idx_q == IDX_LAST) ? '0 : idx_q + 1'b1;
      end else if (cmd_i.init_en) begin
        idx_q <= idx_q + 1'b1;
      end
      if (cmd_i.clear) begin
        cnt_q <= '0;
      end else if (cmd_i.pop_rd && (cnt_q != '0)) begin
        cnt_q <= cnt_m1;
      end else if (push_en && (cnt_q < DEPTH_N)) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (cmd_i.latch) begin
        step_q <= '0;
      end else if (cmd_i.goal_rd) begin
        step_q <= step_q + 1'b1;
      end
      if (cmd_i.wave_clr) begin
        wr_q      <= '0;
        wc_q      <= '0;
        ph_q      <= '0;
        hit_q     <= 1'b0;
        changed_q <= 1'b0;
      end else if (cmd_i.wave_en) begin
        if (cell_end) begin
          ph_q  <= '0;
          hit_q <= 1'b0;
          if ((ph_q == 3'd5) && hit_nx) begin
            changed_q <= 1'b1;
          end
          if (wc_q == DM1) begin
            wc_q <= '0;
            wr_q <= (wr_q == DM1) ? '0 : wr_q + 1'b1;
          end else begin
            wc_q <= wc_q + 1'b1;
          end
        end else begin
          ph_q  <= ph_q + 1'b1;
          hit_q <= hit_nx;
        end
      end
      if (cmd_i.trace_start) begin
        td_q <= '0;
        tv_q <= 1'b0;
      end else if (tstep) begin
        if (!tv_q) begin
          if (inb) begin
            tv_q <= 1'b1;
          end else begin
            td_q <= td_q + 1'b1;
          end
        end else begin
          tv_q <= 1'b0;
          td_q <= match ? 2'd0 : td_q + 1'b1;
        end
      end
    end
  end

  always_comb begin
    sts_o.range_ok    = (32'(start_row_i) < GRID_DIM) && (32'(start_col_i) < GRID_DIM) &&
                        (32'(goal_row_i) < GRID_DIM) && (32'(goal_col_i) < GRID_DIM);
    sts_o.sweep_last  = (idx_q == IDX_LAST);
    sts_o.init_done   = (idx_q == IDX_END);
    sts_o.wave_done   = cmd_i.wave_en && cell_end && (wr_q == DM1) && (wc_q == DM1);
    sts_o.changed     = changed_q;
    sts_o.goal_free   = (dist_rd_q == LABEL_FREE);
    sts_o.goal_lbl_ok = (dist_rd_q != LABEL_FREE) && (dist_rd_q != LABEL_BLOCKED);
    sts_o.step_over   = (step_q > LBL_W'(limit_q));
    sts_o.stack_empty = (cnt_q == '0);
    sts_o.trace_done  = tdone;
  end

  assign status_o      = status_q;
  assign way_row_o     = way_row_q;
  assign way_col_o     = way_col_q;
  assign path_length_o = plen_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= DEPTH_N)
    else $error("stack count beyond depth");
  assert property (@(posedge clk_i) disable iff (!rst_ni) ph_q <= 3'd5)
    else $error("wave phase out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tstep && !cmd_i.trace_start) |=> (k_q == $past(k_q) || k_q == $past(k_q) - 1'b1))
    else $error("trace label moved by more than one");

endmodule
`default_nettype wire

FILE: design/grid_wavefront_path_finder.sv
// channel  dir  handshake                    payload
// in       in   in_valid_i / in_stall_o      mode, cell_row/col/char, start_row/col, goal_row/col
// out      out  out_valid_o / out_stall_i    status, way_row, way_col, path_length
// cfg      in   cfg_valid_i / cfg_ready_o    cfg_data_i (wave_step_limit)
//
// After reset the obstacle map is cleared while the input is stalled.
// Load, pop and clear go straight to the result. Search rebuilds the distance store,
// then runs wave sweeps over every cell (one distance memory port), then traces the
// path back, probing the neighbors of each step; a neighbor off the grid is not read.
// A finished result waits in the output register; the next item is taken meanwhile.
// cfg_ready_o is always high.
`default_nettype none
module grid_wavefront_path_finder import gwpf_pkg::*; #(
  parameter int GRID_DIM   = GRID_DIM_DEF,
  parameter int PATH_DEPTH = PATH_DEPTH_DEF,
  localparam int NW = $clog2(PATH_DEPTH + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          mode_i,
  input  logic [COORD_W-1:0]  cell_row_i,
  input  logic [COORD_W-1:0]  cell_col_i,
  input  logic [CHAR_W-1:0]   cell_char_i,
  input  logic [COORD_W-1:0]  start_row_i,
  input  logic [COORD_W-1:0]  start_col_i,
  input  logic [COORD_W-1:0]  goal_row_i,
  input  logic [COORD_W-1:0]  goal_col_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [COORD_W-1:0]  way_row_o,
  output logic [COORD_W-1:0]  way_col_o,
  output logic [NW-1:0]       path_length_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [LIMIT_W-1:0]  cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  gwpf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_e'(mode_i)),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  gwpf_dp #(
    .GRID_DIM   (GRID_DIM),
    .PATH_DEPTH (PATH_DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_valid_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .cell_row_i    (cell_row_i),
    .cell_col_i    (cell_col_i),
    .cell_char_i   (cell_char_i),
    .start_row_i   (start_row_i),
    .start_col_i   (start_col_i),
    .goal_row_i    (goal_row_i),
    .goal_col_i    (goal_col_i),
    .status_o      (status_o),
    .way_row_o     (way_row_o),
    .way_col_o     (way_col_o),
    .path_length_o (path_length_o)
  );

endmodule
`default_nettype wire
